/* rtl/core/bbhec_pkg.sv */
package bbhec_pkg;

    localparam int unsigned BBHEC_MAX_BYTES = 512;

    localparam int unsigned COL_W    = 6;
    localparam int unsigned LINE_W   = 32;
    localparam int unsigned EBYTE_W  = 9;
    localparam int unsigned EBIT_W   = 3;
    localparam int unsigned STATUS_W = 3;

    localparam int unsigned S_TDATA_W = 80;
    localparam int unsigned M_TDATA_W = 88;

    localparam logic [5:0] PAIR_MASK = 6'h15;

    typedef enum logic [STATUS_W-1:0] {
        ST_UNCHECKED = 3'd0,
        ST_NO_ERROR  = 3'd1,
        ST_DATA_FIX  = 3'd2,
        ST_CODE_ERR  = 3'd3,
        ST_UNCORR    = 3'd4
    } t_status;

    // nibble, pair and single-bit column parities with byte parity in bit 0
    function automatic logic [7:0] col_code(input logic [7:0] b);
        logic [7:0] c;
        c    = '0;
        c[7] = ^(b & 8'hF0);
        c[6] = ^(b & 8'h0F);
        c[5] = ^(b & 8'hCC);
        c[4] = ^(b & 8'h33);
        c[3] = ^(b & 8'hAA);
        c[2] = ^(b & 8'h55);
        c[0] = ^b;
        return c;
    endfunction

endpackage

/* rtl/core/byte_block_hamming_ecc_check.sv */
// Byte-serial Hamming check over a block of bytes. One byte is taken per
// cycle on the slave stream unless a block's last byte waits on a stalled
// result; s_axis_tlast marks the final byte, and a block is closed anyway
// once MAX_BYTES bytes have arrived. Each byte passes an input register and
// a parity update, the last into the result register, and the next block may
// follow at once. The result carries the computed column and line codes and,
// when s_axis_tuser asks for a check on the last byte, the outcome of the
// comparison with the stored code given alongside that byte: no error, the
// byte index and bit of a single bad data bit, a single bad code bit, or
// uncorrectable. Data is never rewritten; the caller flips the reported bit.
module byte_block_hamming_ecc_check
    import bbhec_pkg::*;
#(
    parameter int unsigned MAX_BYTES = BBHEC_MAX_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // data_byte, stored_column_parity, stored_line_parity,
    // stored_line_parity_inverse, zero pad
    input  logic [bbhec_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                            s_axis_tlast,
    // check
    input  logic                            s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // column_parity_out, line_parity_out, line_parity_inverse_out,
    // error_byte_index, error_bit, zero pad
    output logic [bbhec_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [bbhec_pkg::STATUS_W-1:0]  m_axis_tuser
);

    localparam int unsigned CNT_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BYTES - 1);

    // input register
    logic                r_in_valid;
    logic [7:0]          r_data;
    logic                r_last;
    logic                r_check;
    logic [COL_W-1:0]    r_s_col;
    logic [LINE_W-1:0]   r_s_line;
    logic [LINE_W-1:0]   r_s_linv;

    // accumulators
    logic [CNT_W-1:0]    r_cnt;
    logic [7:0]          r_col_acc;
    logic [LINE_W-1:0]   r_line_acc;
    logic [LINE_W-1:0]   r_linv_acc;

    // result register
    logic                r_out_valid;
    logic [COL_W-1:0]    r_o_col;
    logic [LINE_W-1:0]   r_o_line;
    logic [LINE_W-1:0]   r_o_linv;
    t_status             r_o_status;
    logic [EBYTE_W-1:0]  r_o_ebyte;
    logic [EBIT_W-1:0]   r_o_ebit;

    logic                out_free;
    logic                in_last;
    logic                fire;
    logic [7:0]          col_c;
    logic [LINE_W-1:0]   idx32;
    logic [7:0]          n_col_acc;
    logic [LINE_W-1:0]   n_line_acc;
    logic [LINE_W-1:0]   n_linv_acc;
    logic [COL_W-1:0]    col;
    logic [COL_W-1:0]    cd;
    logic [LINE_W-1:0]   ld;
    logic [LINE_W-1:0]   lp;
    logic [2*LINE_W+COL_W-1:0] diff_all;
    logic                one_bit;
    t_status             n_status;
    logic [EBYTE_W-1:0]  n_ebyte;
    logic [EBIT_W-1:0]   n_ebit;

    always_comb begin
        out_free   = !r_out_valid || m_axis_tready;
        in_last    = r_last || (r_cnt == CNT_LAST);
        fire       = r_in_valid && (!in_last || out_free);

        col_c      = col_code(r_data);
        idx32      = LINE_W'(r_cnt);
        n_col_acc  = r_col_acc ^ col_c;
        n_line_acc = col_c[0] ? (r_line_acc ^ idx32) : r_line_acc;
        n_linv_acc = col_c[0] ? (r_linv_acc ^ ~idx32) : r_linv_acc;

        col        = n_col_acc[7:2];
        cd         = r_s_col ^ col;
        ld         = r_s_line ^ n_line_acc;
        lp         = r_s_linv ^ n_linv_acc;
        diff_all   = {ld, lp, cd};
        one_bit    = (diff_all != '0) && ((diff_all & (diff_all - 1'b1)) == '0);

        n_status   = ST_UNCHECKED;
        n_ebyte    = '0;
        n_ebit     = '0;
        if (r_check) begin
            priority if (diff_all == '0) begin
                n_status = ST_NO_ERROR;
            end else if ((ld == ~lp) && (((cd ^ (cd >> 1)) & PAIR_MASK) == PAIR_MASK)) begin
                if (ld > idx32) begin
                    n_status = ST_UNCORR;
                end else begin
                    n_status = ST_DATA_FIX;
                    n_ebyte  = ld[EBYTE_W-1:0];
                    n_ebit   = {cd[5], cd[3], cd[1]};
                end
            end else if (one_bit) begin
                n_status = ST_CODE_ERR;
            end else begin
                n_status = ST_UNCORR;
            end
        end
    end

    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_cnt       <= '0;
            r_col_acc   <= '0;
            r_line_acc  <= '0;
            r_linv_acc  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                if (in_last) begin
                    r_cnt      <= '0;
                    r_col_acc  <= '0;
                    r_line_acc <= '0;
                    r_linv_acc <= '0;
                end else begin
                    r_cnt      <= r_cnt + 1'b1;
                    r_col_acc  <= n_col_acc;
                    r_line_acc <= n_line_acc;
                    r_linv_acc <= n_linv_acc;
                end
            end

            if (fire && in_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_data   <= s_axis_tdata[7:0];
            r_s_col  <= s_axis_tdata[13:8];
            r_s_line <= s_axis_tdata[45:14];
            r_s_linv <= s_axis_tdata[77:46];
            r_last   <= s_axis_tlast;
            r_check  <= s_axis_tuser;
        end
        if (fire && in_last) begin
            r_o_col    <= col;
            r_o_line   <= n_line_acc;
            r_o_linv   <= n_linv_acc;
            r_o_status <= n_status;
            r_o_ebyte  <= n_ebyte;
            r_o_ebit   <= n_ebit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_o_ebit, r_o_ebyte, r_o_linv, r_o_line, r_o_col};
    assign m_axis_tuser  = r_o_status;

endmodule

/* rtl/core/bbhec_check.sv */
module bbhec_check
    import bbhec_pkg::*;
(
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [bbhec_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                            s_axis_tlast,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bbhec_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [bbhec_pkg::STATUS_W-1:0]  m_axis_tuser
);

    logic fix_fields_zero;
    logic s_unused;

    assign fix_fields_zero = (m_axis_tdata[81:70] == '0);
    assign s_unused = s_axis_tvalid & s_axis_tready & s_axis_tlast & s_axis_tuser
                      & s_axis_tdata[0];

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == ST_UNCHECKED) || (m_axis_tuser == ST_NO_ERROR) ||
            (m_axis_tuser == ST_DATA_FIX) || (m_axis_tuser == ST_CODE_ERR) ||
            (m_axis_tuser == ST_UNCORR))
        else $error("status code out of range");

    a_loc_only_on_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_DATA_FIX) |-> fix_fields_zero)
        else $error("error location given without a fixable data bit");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[87:82] == '0) || s_unused)
        else $error("result padding not zero");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind byte_block_hamming_ecc_check bbhec_check u_bbhec_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
